// ===== hw/rtl/particle_pool_engine_macros.svh =====
// Assertion macros shared by the particle pool engine RTL.
`ifndef PARTICLE_POOL_ENGINE_MACROS_SVH
`define PARTICLE_POOL_ENGINE_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication or invariant, disabled during reset.
`define PPE_ASSERT(lbl, clk_s, rst_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
	else $error("particle pool engine assertion failed");
// Condition that must hold in the cycle after a trigger.
`define PPE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
	else $error("particle pool engine assertion failed");
`else
`define PPE_ASSERT(lbl, clk_s, rst_s, prop)
`define PPE_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons)
`endif
`endif

// ===== hw/rtl/ppe_pkg.sv =====
// Types, constants and codes of the particle pool engine.
package ppe_pkg;

	localparam int POOL_DEPTH = 64;
	localparam int AW         = $clog2(POOL_DEPTH);
	localparam int CNT_W      = $clog2(POOL_DEPTH + 1);
	localparam int LIM_W      = (CNT_W > 7) ? CNT_W : 7;
	localparam int IDX_W      = (CNT_W > 6) ? CNT_W : 6;
	localparam int SUM_W      = 16 + CNT_W;
	localparam int DCNT_W     = $clog2(SUM_W + 1);

	// Command codes.
	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_TICK   = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;

	// Configuration register indexes.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ORDER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_POOL_LIMIT = 1'd1;
	localparam logic [6:0] POOL_LIMIT_RESET = 7'd64;

	localparam logic [16:0] AGE_MAX     = 17'h1FFFF;
	localparam logic [16:0] AGE_ONE_FRM = 17'd2;

	// Lane order of one integration pass: position xyz, color rgba, half width.
	localparam int LANES = 8;
	localparam logic [2:0] LANE_POS_LAST = 3'd2;
	localparam logic [2:0] LANE_COL_FIRST = 3'd3;
	localparam logic [2:0] LANE_COL_LAST = 3'd6;
	localparam logic [2:0] LANE_LAST = 3'd7;

	// floor(x / 1000) for x below 2^32 as (x * RECIP) >> RECIP_SHIFT.
	localparam int Q_W         = 22;
	localparam int RECIP_SHIFT = 42;
	localparam logic [32:0] RECIP      = 33'd4398046512;
	localparam logic [31:0] ROUND_HALF = 32'd500;

	typedef struct packed {
		logic [1:0]         command;
		logic [15:0]        delta_ms;
		logic [5:0]         entry_index;
		logic [47:0]        pos_xyz;
		logic [47:0]        vel_xyz;
		logic [63:0]        color_rgba;
		logic [63:0]        color_rate_rgba;
		logic signed [15:0] half_width;
		logic signed [15:0] half_width_rate;
		logic [15:0]        lifetime;
		logic [3:0]         kind;
		logic [47:0]        end_xyz;
	} cmd_word_t;

	typedef struct packed {
		logic [6:0]         live_count;
		logic [47:0]        out_pos;
		logic [63:0]        out_color;
		logic signed [15:0] out_half_width;
		logic [3:0]         out_kind;
		logic [47:0]        out_end;
		logic [16:0]        out_age;
		logic [15:0]        out_lifetime;
		logic               out_valid;
	} rsp_word_t;

	typedef struct packed {
		logic [47:0] pos;
		logic [47:0] vel;
		logic [63:0] color;
		logic [63:0] color_rate;
		logic [15:0] half_width;
		logic [15:0] half_width_rate;
		logic [47:0] end_pt;
		logic [16:0] age;
		logic [15:0] lifetime;
		logic [3:0]  kind;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic        vld;
		logic [2:0]  tag;
		logic [15:0] v;
		logic [15:0] r;
	} lane_req_t;

	typedef struct packed {
		logic        vld;
		logic [2:0]  tag;
		logic [15:0] res;
	} lane_rsp_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_SUM,
		S_DIV,
		S_CULL_RD,
		S_CULL_CHK,
		S_CULL_MOVE,
		S_INS_PLACE,
		S_TK_RD,
		S_TK_CHK,
		S_SH_RD,
		S_SH_WR,
		S_SW_MOVE,
		S_TK_LANE,
		S_TK_DRAIN,
		S_TK_WR,
		S_RD_RD,
		S_RD_OUT,
		S_FINISH
	} state_t;

endpackage

// ===== hw/rtl/ppe_ram.sv =====
// Simple dual-port entry memory with a registered read.
module ppe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one read per cycle; read data holds while re is low.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hw/rtl/ppe_lane.sv =====
// Four-stage lane integrator: v + round(r * delta / 1000), saturated.
module ppe_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  ppe_pkg::lane_req_t req,
	input  logic [15:0]        delta,
	output ppe_pkg::lane_rsp_t rsp
);

	logic                vld_s1, vld_s2, vld_s3, vld_s4;
	logic [2:0]          tag_s1, tag_s2, tag_s3, tag_s4;
	logic [15:0]         v_s1, v_s2, v_s3;
	logic [15:0]         res_s4;
	logic signed [32:0]  prod_c;
	logic signed [32:0]  prod_s1;
	logic [32:0]         mag_c;
	logic [31:0]         mag_s2;
	logic                neg_s2, neg_s3;
	logic [64:0]         full_c;
	logic [ppe_pkg::Q_W-1:0] q_s3;
	logic signed [23:0]  sv_c, qe_c, sum_c;
	logic [15:0]         sat_c;

	// Stage 1: rate times delta.
	assign prod_c = $signed({{17{req.r[15]}}, req.r}) * $signed({17'd0, delta});

	// Stage 2: magnitude plus half of the divisor for rounding.
	assign mag_c = prod_s1[32] ? (33'd0 - 33'(prod_s1)) : 33'(prod_s1);

	// Stage 3: divide by 1000 through the reciprocal.
	assign full_c = 65'(mag_s2) * 65'(ppe_pkg::RECIP);

	// Stage 4: signed add and saturation.
	assign sv_c  = {{8{v_s3[15]}}, v_s3};
	assign qe_c  = 24'(q_s3);
	assign sum_c = neg_s3 ? (sv_c - qe_c) : (sv_c + qe_c);

	always_comb begin
		if (sum_c > 24'sd32767) begin
			sat_c = 16'h7FFF;
		end else if (sum_c < -24'sd32768) begin
			sat_c = 16'h8000;
		end else begin
			sat_c = sum_c[15:0];
		end
	end

	// Result word of the last stage.
	assign rsp = '{vld: vld_s4, tag: tag_s4, res: res_s4};

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= req.vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// Payload of the stages.
	always_ff @(posedge clk) begin
		tag_s1  <= req.tag;
		v_s1    <= req.v;
		prod_s1 <= prod_c;
		tag_s2  <= tag_s1;
		v_s2    <= v_s1;
		neg_s2  <= prod_s1[32];
		mag_s2  <= mag_c[31:0] + ppe_pkg::ROUND_HALF;
		tag_s3  <= tag_s2;
		v_s3    <= v_s2;
		neg_s3  <= neg_s2;
		q_s3    <= full_c[ppe_pkg::RECIP_SHIFT +: ppe_pkg::Q_W];
		tag_s4  <= tag_s3;
		res_s4  <= sat_c;
	end

endmodule

// ===== hw/rtl/ppe_div.sv =====
// Restoring divider, one quotient bit per cycle, for the mean lifetime.
module ppe_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ppe_pkg::SUM_W-1:0] dividend,
	input  logic [ppe_pkg::CNT_W-1:0] divisor,
	output logic                      done,
	output logic [15:0]               quotient
);

	logic                       busy_q;
	logic [ppe_pkg::DCNT_W-1:0] cnt_q;
	logic [ppe_pkg::SUM_W-1:0]  num_q;
	logic [ppe_pkg::SUM_W-1:0]  quo_q;
	logic [ppe_pkg::CNT_W-1:0]  rem_q;
	logic [ppe_pkg::CNT_W:0]    trial_c;
	logic                       fit_c;

	assign trial_c  = {rem_q, num_q[ppe_pkg::SUM_W-1]};
	assign fit_c    = trial_c >= {1'b0, divisor};
	assign quotient = quo_q[15:0];

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= busy_q && (cnt_q == ppe_pkg::DCNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ppe_pkg::DCNT_W'(ppe_pkg::SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - ppe_pkg::DCNT_W'(1);
				if (cnt_q == ppe_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// Shift and subtract step.
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[ppe_pkg::SUM_W-2:0], 1'b0};
			if (fit_c) begin
				rem_q <= ppe_pkg::CNT_W'(trial_c - {1'b0, divisor});
			end else begin
				rem_q <= trial_c[ppe_pkg::CNT_W-1:0];
			end
			quo_q <= {quo_q[ppe_pkg::SUM_W-2:0], fit_c};
		end
	end

endmodule

// ===== hw/rtl/particle_pool_engine.sv =====
// Particle pool engine: one entry memory walked by a command sequencer.
// Read walks S_RD_RD, S_RD_OUT and S_FINISH; insert into a pool with room walks S_INS_PLACE and S_FINISH.
// Insert into a full pool first sums the live lifetimes, divides by the count and culls the entries below the mean.
// Tick passes each surviving entry through the 8-lane integrator and drops each expired entry by
// moving the last live entry into its slot, or by shifting the later entries down when order is kept.
// Reset empties the pool and loads the register defaults; the memory is not cleared.
`include "particle_pool_engine_macros.svh"
module particle_pool_engine (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cmd_valid,
	output logic                                  cmd_stall,
	input  ppe_pkg::cmd_word_t                    cmd_word,
	output logic                                  rsp_valid,
	input  logic                                  rsp_stall,
	output ppe_pkg::rsp_word_t                    rsp_word,
	input  logic                                  cfg_we,
	input  logic [ppe_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ppe_pkg::CFG_DATA_W-1:0]        cfg_data
);

	ppe_pkg::state_t    state_q, state_d;
	ppe_pkg::cmd_word_t cmd_q, cmd_d;
	ppe_pkg::rsp_word_t pend_q, pend_d, rsp_q, rsp_d;
	ppe_pkg::entry_t    ent_q, ent_d, e_rd, new_ent, wr_ent;
	logic               rsp_valid_q, rsp_valid_d;
	logic [ppe_pkg::CNT_W-1:0] count_q, count_d, i_q, i_d, j_q, j_d;
	logic [ppe_pkg::CNT_W-1:0] cnt_m1, j_p1, lim, lim_m1;
	logic [ppe_pkg::LIM_W-1:0] pl_ext, lim_w;
	logic [ppe_pkg::IDX_W-1:0] idx_ext, cnt_ext;
	logic [ppe_pkg::SUM_W-1:0] sum_q, sum_d;
	logic               sumv_q, sumv_d;
	logic [15:0]        ave_q, ave_d;
	logic [2:0]         k_q, k_d, kc;
	logic [15:0]        lres_q [ppe_pkg::LANES];
	logic [15:0]        lres_d [ppe_pkg::LANES];
	logic               keep_order_q;
	logic [6:0]         pool_limit_q;
	logic [17:0]        age_sum;
	logic [16:0]        age_new;
	logic               place_ok, in_lane_pass;

	logic                          ram_we, ram_re;
	logic [ppe_pkg::AW-1:0]        ram_waddr, ram_raddr;
	logic [ppe_pkg::ENTRY_W-1:0]   ram_wdata, ram_rdata;
	ppe_pkg::lane_req_t            lane_req;
	ppe_pkg::lane_rsp_t            lane_rsp;
	logic                          div_start, div_done;
	logic [15:0]                   div_quo;

	ppe_ram #(.WIDTH(ppe_pkg::ENTRY_W), .DEPTH(ppe_pkg::POOL_DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ppe_lane u_lane (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (lane_req),
		.delta  (cmd_q.delta_ms),
		.rsp    (lane_rsp)
	);

	ppe_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_q),
		.divisor  (count_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign cmd_stall = (state_q != ppe_pkg::S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_q;

	// Effective limit and derived counts.
	assign pl_ext = ppe_pkg::LIM_W'(pool_limit_q);
	always_comb begin
		if (pool_limit_q == 7'd0) begin
			lim_w = ppe_pkg::LIM_W'(1);
		end else if (pl_ext > ppe_pkg::LIM_W'(ppe_pkg::POOL_DEPTH)) begin
			lim_w = ppe_pkg::LIM_W'(ppe_pkg::POOL_DEPTH);
		end else begin
			lim_w = pl_ext;
		end
	end
	assign lim     = ppe_pkg::CNT_W'(lim_w);
	assign lim_m1  = lim - ppe_pkg::CNT_W'(1);
	assign cnt_m1  = count_q - ppe_pkg::CNT_W'(1);
	assign j_p1    = j_q + ppe_pkg::CNT_W'(1);
	assign idx_ext = ppe_pkg::IDX_W'(cmd_q.entry_index);
	assign cnt_ext = ppe_pkg::IDX_W'(count_q);

	// Entry read back and age after this tick.
	assign e_rd    = ppe_pkg::entry_t'(ram_rdata);
	assign age_sum = {1'b0, e_rd.age} + 18'(cmd_q.delta_ms);
	assign age_new = (age_sum > 18'(ppe_pkg::AGE_MAX)) ? ppe_pkg::AGE_MAX : age_sum[16:0];
	assign kc      = k_q - ppe_pkg::LANE_COL_FIRST;

	// New particle taken from the command word.
	always_comb begin
		new_ent                 = '0;
		new_ent.pos             = cmd_q.pos_xyz;
		new_ent.vel             = cmd_q.vel_xyz;
		new_ent.color           = cmd_q.color_rgba;
		new_ent.color_rate      = cmd_q.color_rate_rgba;
		new_ent.half_width      = cmd_q.half_width;
		new_ent.half_width_rate = cmd_q.half_width_rate;
		new_ent.end_pt          = cmd_q.end_xyz;
		new_ent.lifetime        = cmd_q.lifetime;
		new_ent.kind            = cmd_q.kind;
	end

	// Integrated entry written back after a tick.
	always_comb begin
		wr_ent            = ent_q;
		wr_ent.pos        = {lres_q[2], lres_q[1], lres_q[0]};
		wr_ent.color      = {lres_q[6], lres_q[5], lres_q[4], lres_q[3]};
		wr_ent.half_width = lres_q[ppe_pkg::LANE_LAST];
	end

	// Sequencer: next state, memory accesses and datapath updates.
	always_comb begin
		state_d     = state_q;
		cmd_d       = cmd_q;
		pend_d      = pend_q;
		rsp_d       = rsp_q;
		rsp_valid_d = rsp_valid_q && rsp_stall;
		ent_d       = ent_q;
		count_d     = count_q;
		i_d         = i_q;
		j_d         = j_q;
		sum_d       = sum_q;
		sumv_d      = sumv_q;
		ave_d       = ave_q;
		k_d         = k_q;
		lres_d      = lres_q;
		ram_we      = 1'b0;
		ram_re      = 1'b0;
		ram_waddr   = i_q[ppe_pkg::AW-1:0];
		ram_raddr   = i_q[ppe_pkg::AW-1:0];
		ram_wdata   = ram_rdata;
		lane_req    = '0;
		div_start   = 1'b0;

		if (lane_rsp.vld) begin
			lres_d[lane_rsp.tag] = lane_rsp.res;
		end

		case (state_q)
			ppe_pkg::S_IDLE: begin
				if (cmd_valid) begin
					cmd_d  = cmd_word;
					pend_d = '0;
					i_d    = '0;
					sum_d  = '0;
					sumv_d = 1'b0;
					case (cmd_word.command)
						ppe_pkg::CMD_INSERT: begin
							state_d = (count_q >= lim) ? ppe_pkg::S_SUM : ppe_pkg::S_INS_PLACE;
						end
						ppe_pkg::CMD_TICK: state_d = ppe_pkg::S_TK_RD;
						ppe_pkg::CMD_READ: state_d = ppe_pkg::S_RD_RD;
						default:           state_d = ppe_pkg::S_FINISH;
					endcase
				end
			end
			// Sum the live lifetimes, one read per cycle.
			ppe_pkg::S_SUM: begin
				sumv_d = (i_q < count_q);
				if (i_q < count_q) begin
					ram_re = 1'b1;
					i_d    = i_q + ppe_pkg::CNT_W'(1);
				end
				if (sumv_q) begin
					sum_d = sum_q + ppe_pkg::SUM_W'(e_rd.lifetime);
				end
				if (!(i_q < count_q) && !sumv_q) begin
					div_start = 1'b1;
					state_d   = ppe_pkg::S_DIV;
				end
			end
			ppe_pkg::S_DIV: begin
				if (div_done) begin
					ave_d   = div_quo;
					i_d     = '0;
					state_d = ppe_pkg::S_CULL_RD;
				end
			end
			// Cull walk: entries below the mean take the last live entry.
			ppe_pkg::S_CULL_RD: begin
				if (i_q < count_q) begin
					ram_re  = 1'b1;
					state_d = ppe_pkg::S_CULL_CHK;
				end else begin
					state_d = ppe_pkg::S_INS_PLACE;
				end
			end
			ppe_pkg::S_CULL_CHK: begin
				if (e_rd.lifetime < ave_q) begin
					ram_re    = 1'b1;
					ram_raddr = cnt_m1[ppe_pkg::AW-1:0];
					state_d   = ppe_pkg::S_CULL_MOVE;
				end else begin
					i_d     = i_q + ppe_pkg::CNT_W'(1);
					state_d = ppe_pkg::S_CULL_RD;
				end
			end
			ppe_pkg::S_CULL_MOVE: begin
				ram_we  = 1'b1;
				count_d = cnt_m1;
				state_d = ppe_pkg::S_CULL_RD;
			end
			// Store the new particle, overwriting the last slot when full.
			ppe_pkg::S_INS_PLACE: begin
				ram_we    = 1'b1;
				ram_wdata = new_ent;
				if (count_q >= lim) begin
					ram_waddr = lim_m1[ppe_pkg::AW-1:0];
					count_d   = lim;
				end else begin
					ram_waddr = count_q[ppe_pkg::AW-1:0];
					count_d   = count_q + ppe_pkg::CNT_W'(1);
				end
				state_d = ppe_pkg::S_FINISH;
			end
			// Tick walk over the live entries.
			ppe_pkg::S_TK_RD: begin
				if (i_q < count_q) begin
					ram_re  = 1'b1;
					state_d = ppe_pkg::S_TK_CHK;
				end else begin
					state_d = ppe_pkg::S_FINISH;
				end
			end
			ppe_pkg::S_TK_CHK: begin
				ent_d = e_rd;
				k_d   = '0;
				if (e_rd.lifetime == 16'd0) begin
					ent_d.age      = ppe_pkg::AGE_ONE_FRM;
					ent_d.lifetime = 16'd1;
					state_d        = ppe_pkg::S_TK_LANE;
				end else if (age_new > {1'b0, e_rd.lifetime}) begin
					if (keep_order_q) begin
						j_d     = i_q;
						state_d = ppe_pkg::S_SH_RD;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = cnt_m1[ppe_pkg::AW-1:0];
						state_d   = ppe_pkg::S_SW_MOVE;
					end
				end else begin
					ent_d.age = age_new;
					state_d   = ppe_pkg::S_TK_LANE;
				end
			end
			// Order-keeping removal: move each later entry down by one.
			ppe_pkg::S_SH_RD: begin
				if (j_p1 < count_q) begin
					ram_re    = 1'b1;
					ram_raddr = j_p1[ppe_pkg::AW-1:0];
					state_d   = ppe_pkg::S_SH_WR;
				end else begin
					count_d = cnt_m1;
					state_d = ppe_pkg::S_TK_RD;
				end
			end
			ppe_pkg::S_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = j_q[ppe_pkg::AW-1:0];
				j_d       = j_p1;
				state_d   = ppe_pkg::S_SH_RD;
			end
			ppe_pkg::S_SW_MOVE: begin
				ram_we  = 1'b1;
				count_d = cnt_m1;
				state_d = ppe_pkg::S_TK_RD;
			end
			// Issue the eight lanes of the entry to the integrator.
			ppe_pkg::S_TK_LANE: begin
				lane_req.vld = 1'b1;
				lane_req.tag = k_q;
				if (k_q <= ppe_pkg::LANE_POS_LAST) begin
					lane_req.v = ent_q.pos[{k_q[1:0], 4'b0000} +: 16];
					lane_req.r = ent_q.vel[{k_q[1:0], 4'b0000} +: 16];
				end else if (k_q <= ppe_pkg::LANE_COL_LAST) begin
					lane_req.v = ent_q.color[{kc[1:0], 4'b0000} +: 16];
					lane_req.r = ent_q.color_rate[{kc[1:0], 4'b0000} +: 16];
				end else begin
					lane_req.v = ent_q.half_width;
					lane_req.r = ent_q.half_width_rate;
				end
				k_d = k_q + 3'd1;
				if (k_q == ppe_pkg::LANE_LAST) begin
					state_d = ppe_pkg::S_TK_DRAIN;
				end
			end
			ppe_pkg::S_TK_DRAIN: begin
				if (lane_rsp.vld && (lane_rsp.tag == ppe_pkg::LANE_LAST)) begin
					state_d = ppe_pkg::S_TK_WR;
				end
			end
			ppe_pkg::S_TK_WR: begin
				ram_we    = 1'b1;
				ram_wdata = wr_ent;
				i_d       = i_q + ppe_pkg::CNT_W'(1);
				state_d   = ppe_pkg::S_TK_RD;
			end
			// Read command.
			ppe_pkg::S_RD_RD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_ext[ppe_pkg::AW-1:0];
				state_d   = ppe_pkg::S_RD_OUT;
			end
			ppe_pkg::S_RD_OUT: begin
				if ((idx_ext < cnt_ext) && (idx_ext < ppe_pkg::IDX_W'(ppe_pkg::POOL_DEPTH))) begin
					pend_d.out_pos        = e_rd.pos;
					pend_d.out_color      = e_rd.color;
					pend_d.out_half_width = e_rd.half_width;
					pend_d.out_kind       = e_rd.kind;
					pend_d.out_end        = e_rd.end_pt;
					pend_d.out_age        = e_rd.age;
					pend_d.out_lifetime   = e_rd.lifetime;
					pend_d.out_valid      = 1'b1;
				end
				state_d = ppe_pkg::S_FINISH;
			end
			// Hand the word to the output register once it is free.
			ppe_pkg::S_FINISH: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_d            = pend_q;
					rsp_d.live_count = 7'(count_q);
					rsp_valid_d      = 1'b1;
					state_d          = ppe_pkg::S_IDLE;
				end
			end
			default: state_d = ppe_pkg::S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppe_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control registers and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			rsp_valid_q  <= 1'b0;
			sumv_q       <= 1'b0;
			keep_order_q <= 1'b0;
			pool_limit_q <= ppe_pkg::POOL_LIMIT_RESET;
		end else begin
			count_q     <= count_d;
			rsp_valid_q <= rsp_valid_d;
			sumv_q      <= sumv_d;
			if (cfg_we) begin
				case (cfg_index)
					ppe_pkg::CFG_KEEP_ORDER: keep_order_q <= cfg_data[0];
					ppe_pkg::CFG_POOL_LIMIT: pool_limit_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		pend_q <= pend_d;
		rsp_q  <= rsp_d;
		ent_q  <= ent_d;
		i_q    <= i_d;
		j_q    <= j_d;
		sum_q  <= sum_d;
		ave_q  <= ave_d;
		k_q    <= k_d;
		lres_q <= lres_d;
	end

	// Conditions checked by the assertions below.
	assign place_ok     = (count_q != '0) && (count_q <= lim);
	assign in_lane_pass = (state_q == ppe_pkg::S_TK_LANE) || (state_q == ppe_pkg::S_TK_DRAIN);

	// A placed particle always leaves the pool non-empty and within the limit.
	`PPE_ASSERT_NEXT(a_place_bound, clk, arst_n, state_q == ppe_pkg::S_INS_PLACE, place_ok)
	// Integrator results only return during the lane pass of a tick.
	`PPE_ASSERT(a_lane_in_tick, clk, arst_n, lane_rsp.vld |-> in_lane_pass)
	// The divider finishes only while the sequencer waits for it.
	`PPE_ASSERT(a_div_in_wait, clk, arst_n, div_done |-> (state_q == ppe_pkg::S_DIV))
	// The tick walk index never passes the live count.
	`PPE_ASSERT(a_walk_bound, clk, arst_n, (state_q == ppe_pkg::S_TK_RD) |-> (i_q <= count_q))

endmodule
